[rtl/core/bct_pkg.sv]
// Shared types, constants and helper functions for the binary contour tracer.
// Depends on nothing; the channel interfaces and every module but bct_ram import it.
package bct_pkg;

  localparam int MAP_WIDTH  = 64;
  localparam int MAP_HEIGHT = 64;
  localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W     = $clog2(MAP_CELLS);
  localparam int COL_W      = $clog2(MAP_WIDTH);
  localparam int ROW_W      = $clog2(MAP_HEIGHT);
  // room for the one-cell step outside the map on either side
  localparam int CRD_W      = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
  localparam int TRIES_W    = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic [ROW_W-1:0]        row_t;
  typedef logic signed [CRD_W-1:0] coord_t;
  typedef logic [TRIES_W-1:0]      tries_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_START = 2'd2,
    OP_STEP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    HD_RIGHT = 2'd0,
    HD_DOWN  = 2'd1,
    HD_LEFT  = 2'd2,
    HD_UP    = 2'd3
  } heading_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_SET,
    ST_START,
    ST_CHK_AHEAD,
    ST_CHK_SIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } item_t;

  typedef struct packed {
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        last_point;
    logic [15:0] point_count;
    logic [31:0] sum_x;
    logic [31:0] sum_y;
    logic        fault;
  } result_t;

  function automatic heading_t turn_ccw(heading_t h);
    return heading_t'(h - 2'd1);
  endfunction

  function automatic heading_t turn_cw(heading_t h);
    return heading_t'(h + 2'd1);
  endfunction

  function automatic coord_t step_dx(heading_t h);
    coord_t d;
    case (h)
      HD_RIGHT: d = coord_t'(1);
      HD_LEFT:  d = coord_t'(-1);
      default:  d = '0;
    endcase
    return d;
  endfunction

  function automatic coord_t step_dy(heading_t h);
    coord_t d;
    case (h)
      HD_DOWN: d = coord_t'(1);
      HD_UP:   d = coord_t'(-1);
      default: d = '0;
    endcase
    return d;
  endfunction

  // clockwise-side neighbor of the cell ahead
  function automatic coord_t side_dx(heading_t h);
    coord_t d;
    case (h)
      HD_DOWN: d = coord_t'(-1);
      HD_UP:   d = coord_t'(1);
      default: d = '0;
    endcase
    return d;
  endfunction

  function automatic coord_t side_dy(heading_t h);
    coord_t d;
    case (h)
      HD_RIGHT: d = coord_t'(1);
      HD_LEFT:  d = coord_t'(-1);
      default:  d = '0;
    endcase
    return d;
  endfunction

  function automatic logic in_map(coord_t x, coord_t y);
    return !x[CRD_W-1] && (x < coord_t'(MAP_WIDTH)) &&
           !y[CRD_W-1] && (y < coord_t'(MAP_HEIGHT));
  endfunction

  function automatic addr_t map_addr(coord_t x, coord_t y);
    return addr_t'(y[ROW_W-1:0]) * addr_t'(MAP_WIDTH) + addr_t'(x[COL_W-1:0]);
  endfunction

endpackage

[rtl/core/bct_if.sv]
// Item and result channels of the binary contour tracer: valid, ready, payload.
// Depends on bct_pkg for the payload structs.
interface bct_item_if;
  import bct_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bct_result_if;
  import bct_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/bct_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module bct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/binary_contour_tracer_top.sv]
// Binary contour tracer top level: object map RAM, walker sequencer, result register.
// Depends on bct_pkg, bct_item_if, bct_result_if and bct_ram.
//
//   port       dir   kind             carries
//   item       in    valid/ready      opcode, pixel_x, pixel_y
//   result     out   valid/ready      point, last_point, point_count, sums, fault
//   cfg_*      in    write enable     origin_x (index 0), origin_y (index 1)
//
// Sequencing: set pixel and start trace each pass through their own state; clear map
//   is a write sweep over the map RAM, one cell a cycle. A step reads the map RAM
//   once per heading tried, plus once for the corner cell, then emits the result.
//   The single read port of the map RAM keeps these reads one after another.
// Reset: the same sweep clears the map; item.ready is low meanwhile.
// Stalls: a finished result waits in the output register while the next item is
//   taken; only the next step's emit waits for that register to drain.
module binary_contour_tracer_top (
  input  logic                           clk,
  input  logic                           rst,
  bct_item_if.sink                       item,
  bct_result_if.source                   result,
  input  logic                           cfg_we,
  input  logic [bct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bct_pkg::*;

  state_t      state, state_next;
  logic [15:0] origin_x, origin_y;
  item_t       item_q;
  addr_t       sweep_addr;

  // walker state
  col_t        walker_x, start_x;
  row_t        walker_y, start_y;
  heading_t    heading;
  logic [15:0] emitted_count;
  logic [31:0] x_total, y_total;
  logic        trace_active;

  // per-step working registers
  coord_t      ahd_x, ahd_y;
  heading_t    ahd_h;
  tries_t      tries;
  coord_t      fin_x, fin_y;
  heading_t    fin_h;
  logic        fin_moved;
  logic [15:0] fin_img_x, fin_img_y;

  logic        res_valid;
  result_t     res_q, res_next;

  // map RAM ports
  logic        ram_we, ram_wdata, ram_rdata;
  addr_t       ram_waddr, ram_raddr;

  logic        accept, step_go, res_load, sweep_last, last_try, at_start;
  coord_t      wx, wy, probe_x, probe_y, side_x, side_y;
  heading_t    probe_h;
  logic        probe_in, side_in;
  logic        probe_load, fin_load, fin_sel_moved;
  coord_t      fin_sel_x, fin_sel_y;
  heading_t    fin_sel_h;
  logic [15:0] set_col, set_row, start_row;
  logic        set_hit, start_hit;

  bct_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign accept     = item.valid && item.ready;
  assign step_go    = accept && (item.data.opcode == OP_STEP);
  assign sweep_last = sweep_addr == addr_t'(MAP_CELLS - 1);
  assign last_try   = tries == '1;

  // image to map coordinates for set and start
  assign set_col   = item_q.pixel_x - origin_x;
  assign set_row   = item_q.pixel_y - origin_y;
  assign start_row = item_q.pixel_y - 16'd1 - origin_y;
  assign set_hit   = (set_col < 16'(MAP_WIDTH)) && (set_row < 16'(MAP_HEIGHT));
  assign start_hit = (set_col < 16'(MAP_WIDTH)) && (start_row < 16'(MAP_HEIGHT));

  // The walker never moves during a step, so every probe starts from it.
  // On entry try the current heading; after a blocked cell turn counter-clockwise.
  assign wx       = coord_t'(walker_x);
  assign wy       = coord_t'(walker_y);
  assign probe_h  = (state == ST_IDLE) ? heading : turn_ccw(ahd_h);
  assign probe_x  = wx + step_dx(probe_h);
  assign probe_y  = wy + step_dy(probe_h);
  assign probe_in = in_map(probe_x, probe_y);
  assign side_x   = ahd_x + side_dx(ahd_h);
  assign side_y   = ahd_y + side_dy(ahd_h);
  assign side_in  = in_map(side_x, side_y);
  assign at_start = (fin_x == coord_t'(start_x)) && (fin_y == coord_t'(start_y));

  // walk decisions: what to read next and where the step ends
  always_comb begin
    probe_load    = 1'b0;
    fin_load      = 1'b0;
    fin_sel_x     = probe_x;
    fin_sel_y     = probe_y;
    fin_sel_h     = ahd_h;
    fin_sel_moved = 1'b0;
    case (state)
      ST_IDLE: begin
        if (step_go && trace_active) begin
          if (probe_in) begin
            probe_load = 1'b1;
          end else begin
            fin_load = 1'b1;
          end
        end
      end
      ST_CHK_AHEAD: begin
        if (ram_rdata) begin
          if (last_try) begin
            // enclosed on all four sides: report the walker itself
            fin_load  = 1'b1;
            fin_sel_x = wx;
            fin_sel_y = wy;
          end else if (probe_in) begin
            probe_load = 1'b1;
          end else begin
            fin_load = 1'b1;
          end
        end else if (!side_in) begin
          // corner step leaves the map
          fin_load  = 1'b1;
          fin_sel_x = side_x;
          fin_sel_y = side_y;
        end
      end
      ST_CHK_SIDE: begin
        fin_load      = 1'b1;
        fin_sel_moved = 1'b1;
        if (ram_rdata) begin
          fin_sel_x = ahd_x;
          fin_sel_y = ahd_y;
        end else begin
          fin_sel_x = side_x;
          fin_sel_y = side_y;
          fin_sel_h = turn_cw(ahd_h);
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (item.data.opcode)
            OP_CLEAR: state_next = ST_SWEEP;
            OP_SET:   state_next = ST_SET;
            OP_START: state_next = ST_START;
            default:  state_next = probe_load ? ST_CHK_AHEAD : ST_EMIT;
          endcase
        end
      end
      ST_SET:       state_next = ST_IDLE;
      ST_START:     state_next = ST_IDLE;
      ST_CHK_AHEAD: begin
        if (probe_load) begin
          state_next = ST_CHK_AHEAD;
        end else if (fin_load) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_CHK_SIDE;
        end
      end
      ST_CHK_SIDE:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (res_load) state_next = ST_IDLE;
      end
      default:      state_next = ST_SWEEP;
    endcase
  end

  // outputs: handshakes and map RAM control
  always_comb begin
    item.ready = state == ST_IDLE;
    res_load   = (state == ST_EMIT) && (!res_valid || result.ready);
    ram_we     = 1'b0;
    ram_waddr  = sweep_addr;
    ram_wdata  = 1'b0;
    case (state)
      ST_SWEEP: ram_we = 1'b1;
      ST_SET: begin
        ram_we    = set_hit;
        ram_waddr = map_addr(coord_t'(set_col[COL_W-1:0]), coord_t'(set_row[ROW_W-1:0]));
        ram_wdata = 1'b1;
      end
      default: begin
      end
    endcase
    // read the corner cell once the cell ahead came back clear
    if ((state == ST_CHK_AHEAD) && !ram_rdata) begin
      ram_raddr = map_addr(side_x, side_y);
    end else begin
      ram_raddr = map_addr(probe_x, probe_y);
    end
  end

  // result of a step
  always_comb begin
    res_next             = '0;
    res_next.point_count = emitted_count;
    res_next.sum_x       = x_total;
    res_next.sum_y       = y_total;
    res_next.fault       = 1'b1;
    if (trace_active) begin
      res_next.point_x = fin_img_x;
      res_next.point_y = fin_img_y;
      if (fin_moved) begin
        res_next.fault       = emitted_count == 16'hFFFF;
        res_next.point_count = (emitted_count == 16'hFFFF) ? emitted_count
                                                           : emitted_count + 16'd1;
        res_next.sum_x       = x_total + 32'(fin_img_x);
        res_next.sum_y       = y_total + 32'(fin_img_y);
        res_next.last_point  = at_start;
      end
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_q;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_addr    <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
      walker_x      <= '0;
      walker_y      <= '0;
      start_x       <= '0;
      start_y       <= '0;
      heading       <= HD_RIGHT;
      emitted_count <= '0;
      x_total       <= '0;
      y_total       <= '0;
      trace_active  <= 1'b0;
      tries         <= '0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: origin_x <= cfg_data;
          REG_ORIGIN_Y: origin_y <= cfg_data;
          default: begin
          end
        endcase
      end

      // wrap at the end so the next clear starts from cell zero
      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + addr_t'(1);
      end

      if (step_go) begin
        tries <= '0;
      end else if ((state == ST_CHK_AHEAD) && ram_rdata) begin
        tries <= tries + tries_t'(1);
      end

      if (state == ST_START) begin
        emitted_count <= '0;
        x_total       <= '0;
        y_total       <= '0;
        heading       <= HD_RIGHT;
        trace_active  <= start_hit;
        if (start_hit) begin
          walker_x <= set_col[COL_W-1:0];
          walker_y <= start_row[ROW_W-1:0];
          start_x  <= set_col[COL_W-1:0];
          start_y  <= start_row[ROW_W-1:0];
        end
      end

      if (res_load && trace_active) begin
        if (fin_moved) begin
          walker_x      <= fin_x[COL_W-1:0];
          walker_y      <= fin_y[ROW_W-1:0];
          heading       <= fin_h;
          emitted_count <= res_next.point_count;
          x_total       <= res_next.sum_x;
          y_total       <= res_next.sum_y;
          trace_active  <= !at_start;
        end else begin
          // left the map or enclosed: end the trace
          trace_active <= 1'b0;
        end
      end

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item.data;
    end
    if (probe_load) begin
      ahd_x <= probe_x;
      ahd_y <= probe_y;
      ahd_h <= probe_h;
    end
    if (fin_load) begin
      fin_x     <= fin_sel_x;
      fin_y     <= fin_sel_y;
      fin_h     <= fin_sel_h;
      fin_moved <= fin_sel_moved;
      fin_img_x <= origin_x + 16'(fin_sel_x);
      fin_img_y <= origin_y + 16'(fin_sel_y);
    end
    if (res_load) begin
      res_q <= res_next;
    end
  end

  // a last point always closes the trace
  a_last_ends_trace: assert property (@(posedge clk) disable iff (rst)
    res_load && res_next.last_point |=> !trace_active)
    else $error("trace still active after last point");

  // a clean move advances the count by exactly one
  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    res_load && trace_active && fin_moved && !res_next.fault
    |=> emitted_count == $past(emitted_count) + 16'd1)
    else $error("point count did not advance by one");

  // the clearing sweep runs to its end before anything else
  a_sweep_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |=> (state == ST_SWEEP) || (state == ST_IDLE))
    else $error("map sweep interrupted");

  // an active walker always sits inside the map
  a_walker_inside: assert property (@(posedge clk) disable iff (rst)
    trace_active |-> (int'(walker_x) < MAP_WIDTH) && (int'(walker_y) < MAP_HEIGHT))
    else $error("active walker outside the map");

endmodule

[tb/sv/tb_binary_contour_tracer_top.sv]
// Self-checking bench for binary_contour_tracer_top: drives map, start and step
// transactions, predicts each contour point and compares it field by field.
// Depends on bct_pkg, bct_item_if, bct_result_if and the tracer RTL.
module tb_binary_contour_tracer_top;
  import bct_pkg::*;

  // Generous ceiling: every map clear sweeps the whole map RAM and most random
  // objects start with one; steps wait on map RAM reads and on receiver stalls.
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int     MAX_PRINTED = 200;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bct_item_if   item_bus ();
  bct_result_if point_bus ();

  binary_contour_tracer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .item      (item_bus),
    .result    (point_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow state of the tracer, kept in map coordinates.
  logic [MAP_CELLS-1:0] shadow_map;
  int                   walker_x, walker_y, anchor_x, anchor_y;
  heading_t             walker_hd;
  logic [15:0]          trail_count;
  logic [31:0]          trail_sum_x, trail_sum_y;
  bit                   tracing;
  logic [15:0]          org_x, org_y;

  // Contour points still owed by the DUT, oldest first.
  result_t expected_points[$];

  int     error_count;
  int     item_tally;
  int     burst_left;
  int     rx_mode, rx_hold;
  longint rx_tick;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Report one failure on one line; stop printing after a while but keep counting.
  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("mismatch @%0d: %s", cycles, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) note_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Map offsets for a heading: the cell ahead, and the clockwise side of that cell.
  function automatic void heading_offsets(input heading_t h, output int ax, output int ay,
                                          output int sx, output int sy);
    case (h)
      HD_RIGHT: begin ax = 1;  ay = 0;  sx = 0;  sy = 1;  end
      HD_DOWN:  begin ax = 0;  ay = 1;  sx = -1; sy = 0;  end
      HD_LEFT:  begin ax = -1; ay = 0;  sx = 0;  sy = -1; end
      default:  begin ax = 0;  ay = -1; sx = 1;  sy = 0;  end
    endcase
  endfunction

  function automatic bit on_map(input int x, input int y);
    return x >= 0 && x < MAP_WIDTH && y >= 0 && y < MAP_HEIGHT;
  endfunction

  // Cells off the map read as clear.
  function automatic bit occupied(input int x, input int y);
    if (!on_map(x, y)) return 1'b0;
    return shadow_map[y * MAP_WIDTH + x];
  endfunction

  // Apply one accepted transaction to the shadow state; queue the point a step owes.
  task automatic predict_contour_item(input item_t it);
    logic [15:0] col, row;
    result_t     r;
    int          x, y, nx, ny, ax, ay, sx, sy, k;
    heading_t    h;
    bit          moved, escaped;
    r = '0;
    case (it.opcode)
      OP_CLEAR: shadow_map = '0;
      OP_SET: begin
        col = it.pixel_x - org_x;
        row = it.pixel_y - org_y;
        // a set off the map is dropped
        if (col < MAP_WIDTH && row < MAP_HEIGHT) shadow_map[row * MAP_WIDTH + col] = 1'b1;
      end
      OP_START: begin
        col = it.pixel_x - org_x;
        row = it.pixel_y - 16'd1 - org_y;
        trail_count = '0;
        trail_sum_x = '0;
        trail_sum_y = '0;
        walker_hd   = HD_RIGHT;
        tracing     = (col < MAP_WIDTH && row < MAP_HEIGHT);
        if (tracing) begin
          walker_x = col;
          walker_y = row;
          anchor_x = col;
          anchor_y = row;
        end
      end
      default: begin
        r.point_count = trail_count;
        r.sum_x       = trail_sum_x;
        r.sum_y       = trail_sum_y;
        r.fault       = 1'b1;
        if (tracing) begin
          x = walker_x;
          y = walker_y;
          h = walker_hd;
          moved   = 1'b0;
          escaped = 1'b0;
          // Try up to four headings: blocked ahead turns counter-clockwise,
          // a clear corner cell swings the walker round and turns clockwise.
          for (k = 0; k < 4; k++) begin
            heading_offsets(h, ax, ay, sx, sy);
            nx = x + ax;
            ny = y + ay;
            if (!on_map(nx, ny)) begin
              x = nx;
              y = ny;
              escaped = 1'b1;
              break;
            end
            if (occupied(nx, ny)) begin
              h = heading_t'(h - 2'd1);
              continue;
            end
            if (!occupied(nx + sx, ny + sy)) begin
              nx = nx + sx;
              ny = ny + sy;
              h  = heading_t'(h + 2'd1);
            end
            x = nx;
            y = ny;
            if (!on_map(x, y)) escaped = 1'b1;
            else moved = 1'b1;
            break;
          end
          r.point_x = org_x + 16'(x);
          r.point_y = org_y + 16'(y);
          if (!moved || escaped) begin
            // left the map or boxed in: the trace ends, totals unchanged
            tracing = 1'b0;
          end else begin
            walker_x  = x;
            walker_y  = y;
            walker_hd = h;
            if (trail_count != 16'hFFFF) begin
              trail_count++;
              r.fault = 1'b0;
            end
            trail_sum_x += {16'd0, r.point_x};
            trail_sum_y += {16'd0, r.point_y};
            if (x == anchor_x && y == anchor_y) begin
              r.last_point = 1'b1;
              tracing      = 1'b0;
            end
            r.point_count = trail_count;
            r.sum_x       = trail_sum_x;
            r.sum_y       = trail_sum_y;
          end
        end
        expected_points.push_back(r);
      end
    endcase
  endtask

  // Send one transaction. The sender runs in bursts of random length with
  // random gaps; valid stays high across a burst.
  task automatic send_op(input op_t op, input logic [15:0] px, input logic [15:0] py);
    item_t       it;
    int          gap;
    logic [15:0] col, row;
    it.opcode  = op;
    it.pixel_x = px;
    it.pixel_y = py;
    col = px - org_x;
    row = py - org_y;
    // sets that land off the map do nothing and are not counted
    if (!(op == OP_SET && (col >= MAP_WIDTH || row >= MAP_HEIGHT))) item_tally++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_bus.valid <= 1'b1;
    item_bus.data  <= it;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    predict_contour_item(it);
  endtask

  // Keep stepping while the shadow walker is on a live trace.
  task automatic step_until_done(input int cap);
    int n;
    n = 0;
    while (tracing && n < cap) begin
      send_op(OP_STEP, 16'($urandom), 16'($urandom));
      n++;
    end
  endtask

  // Write both origin registers with the block idle. A clear may still be
  // sweeping after the last point came back, so hold off for a full sweep.
  task automatic write_origin(input logic [15:0] ox, input logic [15:0] oy);
    item_bus.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (MAP_CELLS + 16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data  <= ox;
    @(posedge clk);
    org_x = ox;
    cfg_index <= REG_ORIGIN_Y;
    cfg_data  <= oy;
    @(posedge clk);
    org_y = oy;
    cfg_we <= 1'b0;
  endtask

  // Steps with no live trace: after reset, and after starts that fall off the map.
  task automatic test_no_trace;
    send_op(OP_STEP, 16'd0, 16'd0);
    send_op(OP_START, 16'hFFFF, 16'hFFFF);
    send_op(OP_STEP, 16'hFFFF, 16'hFFFF);
    send_op(OP_START, 16'd5, 16'd0);          // row above row zero wraps off the map
    send_op(OP_STEP, 16'd5, 16'd0);
  endtask

  // Sets at the field extremes, then walks that leave the map right and left.
  task automatic test_map_edges;
    send_op(OP_CLEAR, 16'hFFFF, 16'h0000);
    send_op(OP_SET, 16'd0, 16'd0);
    send_op(OP_SET, 16'hFFFF, 16'hFFFF);      // off the map, dropped
    send_op(OP_SET, 16'd63, 16'd1);
    send_op(OP_START, 16'd63, 16'd1);         // walker at the right edge, heading out
    send_op(OP_STEP, 16'd0, 16'd0);
    send_op(OP_SET, 16'd0, 16'd5);
    send_op(OP_START, 16'd0, 16'd5);          // corner swing, then off the left edge
    step_until_done(8);
  endtask

  // All four neighbors set: the walker cannot move.
  task automatic test_enclosed_walker;
    send_op(OP_CLEAR, 16'd0, 16'hFFFF);
    send_op(OP_SET, 16'd11, 16'd10);
    send_op(OP_SET, 16'd9, 16'd10);
    send_op(OP_SET, 16'd10, 16'd9);
    send_op(OP_SET, 16'd10, 16'd11);
    send_op(OP_START, 16'd10, 16'd11);
    send_op(OP_STEP, 16'd0, 16'd0);
    send_op(OP_STEP, 16'd0, 16'd0);           // trace already ended
  endtask

  // Lone pixel: four corner swings bring the walker home with the last-point flag.
  task automatic test_single_pixel_loop;
    send_op(OP_CLEAR, 16'd0, 16'd0);
    send_op(OP_SET, 16'd20, 16'd20);
    send_op(OP_START, 16'd20, 16'd20);
    step_until_done(8);
  endtask

  // One random blob in a small box, traced mostly from its top row.
  task automatic trace_random_object(input bit fresh);
    bit          blob [0:9][0:9];
    int          w, hgt, bc, br, c, r, lead, n;
    logic [15:0] sx, sy;
    w   = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    hgt = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
    // Push some boxes against the map border so walks run off it.
    case ($urandom_range(0, 7))
      0:       bc = 0;
      1:       bc = MAP_WIDTH - w;
      default: bc = $urandom_range(1, MAP_WIDTH - 1 - w);
    endcase
    case ($urandom_range(0, 7))
      0:       br = 0;
      1:       br = 1;
      2:       br = MAP_HEIGHT - hgt;
      default: br = $urandom_range(2, MAP_HEIGHT - 1 - hgt);
    endcase
    for (r = 0; r < 10; r++)
      for (c = 0; c < 10; c++)
        blob[r][c] = (r < hgt && c < w && $urandom_range(0, 99) < 65);
    blob[0][$urandom_range(0, w - 1)] = 1'b1;
    lead = 0;
    while (!blob[0][lead]) lead++;

    if (fresh || $urandom_range(0, 4) != 0) send_op(OP_CLEAR, 16'($urandom), 16'($urandom));
    for (r = 0; r < hgt; r++)
      for (c = 0; c < w; c++)
        if (blob[r][c]) send_op(OP_SET, 16'(org_x + bc + c), 16'(org_y + br + r));
    repeat ($urandom_range(0, 2)) send_op(OP_SET, 16'($urandom), 16'($urandom));

    // Mostly start at the leftmost top-row pixel; sometimes anywhere.
    case ($urandom_range(0, 9))
      0: begin
        sx = 16'($urandom);
        sy = 16'($urandom);
      end
      1: begin
        sx = 16'(org_x + bc + $urandom_range(0, w - 1));
        sy = 16'(org_y + br + $urandom_range(0, hgt - 1));
      end
      default: begin
        sx = 16'(org_x + bc + lead);
        sy = 16'(org_y + br);
      end
    endcase
    send_op(OP_START, sx, sy);

    n = 0;
    while (tracing && n < 150) begin
      // now and then grow the object under the walker's feet
      if ($urandom_range(0, 39) == 0)
        send_op(OP_SET, 16'(org_x + bc + $urandom_range(0, w)),
                16'(org_y + br + $urandom_range(0, hgt)));
      send_op(OP_STEP, 16'($urandom), 16'($urandom));
      n++;
    end
    repeat (($urandom_range(0, 3) == 0) ? 1 : 0) send_op(OP_STEP, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_random_objects(input int target);
    trace_random_object(1'b1);
    while (item_tally < target) trace_random_object(1'b0);
  endtask

  // Result side: check each accepted transaction against the oldest prediction,
  // then pick next cycle's ready from one of four stall patterns, chosen anew at random.
  task automatic check_point(input result_t got);
    result_t want;
    if (expected_points.size() == 0) begin
      note_error($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_points.pop_front();
    compare_field("point_x", got.point_x, want.point_x);
    compare_field("point_y", got.point_y, want.point_y);
    compare_field("last_point", got.last_point, want.last_point);
    compare_field("point_count", got.point_count, want.point_count);
    compare_field("sum_x", got.sum_x, want.sum_x);
    compare_field("sum_y", got.sum_y, want.sum_y);
    compare_field("fault", got.fault, want.fault);
  endtask

  always @(posedge clk) begin
    if (point_bus.valid === 1'b1 && point_bus.ready === 1'b1) check_point(point_bus.data);
    rx_tick++;
    if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_mode == 0) begin
      point_bus.ready <= 1'b1;
    end else if (rx_mode == 1) begin
      point_bus.ready <= (rx_tick % 3 != 0);
    end else if (rx_mode == 2) begin
      point_bus.ready <= 1'($urandom_range(0, 1));
    end else if (rx_hold > 0) begin
      rx_hold--;
      point_bus.ready <= 1'b0;
    end else begin
      // long stalls of random length, now and then
      rx_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : 0;
      point_bus.ready <= 1'b1;
    end
  end

  initial begin
    // Known values on every input from time zero; shadow state as after reset.
    rst            = 1'b1;
    item_bus.valid = 1'b0;
    item_bus.data  = '0;
    point_bus.ready = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_ORIGIN_X;
    cfg_data       = '0;
    shadow_map     = '0;
    walker_x = 0;
    walker_y = 0;
    anchor_x = 0;
    anchor_y = 0;
    walker_hd   = HD_RIGHT;
    trail_count = '0;
    trail_sum_x = '0;
    trail_sum_y = '0;
    tracing     = 1'b0;
    org_x = '0;
    org_y = '0;
    error_count = 0;
    item_tally  = 0;
    burst_left  = 0;
    rx_mode     = 0;
    rx_hold     = 0;
    rx_tick     = 0;
    cycles      = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed cases at the reset origin; ready stays low through the reset sweep.
    test_no_trace();
    test_map_edges();
    test_enclosed_walker();
    test_single_pixel_loop();

    // Random objects under several origins, the extremes and wrapping ones among them.
    item_tally = 0;
    write_origin(16'hFFFF, 16'hFFFF);
    test_random_objects(100);
    write_origin(16'h0000, 16'h0000);
    test_random_objects(200);
    write_origin(16'hFFD0, 16'h0003);
    test_random_objects(300);
    write_origin(16'($urandom), 16'($urandom));
    test_random_objects(400);
    write_origin(16'h0005, 16'hFFE8);
    test_random_objects(500);

    // Drain: drop valid, wait for every owed point, then allow a late stray one.
    item_bus.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
